// ===== design/ued_pkg.sv =====
// shared types, constants and helpers for the character edit distance block
package ued_pkg;

   localparam int MAX_CHARS_DEF = 64;
   localparam int ASM_W         = 56;
   localparam int SEEN_W        = 3;
   localparam int CODE_W        = ASM_W + SEEN_W;
   localparam int BYTE_W        = 8;
   localparam int DIST_W        = 7;
   localparam int LANES         = 7;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SWEEP,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic accept;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic start_sweep;
      logic emit;
      logic sweep_done;
   } status_type;

   typedef struct packed {
      logic [ASM_W-1:0]  asm_bytes;
      logic [SEEN_W-1:0] expected;
      logic [SEEN_W-1:0] seen;
   } asm_type;

   function automatic logic [SEEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
      logic [SEEN_W-1:0] n;
      logic              run;
      n   = SEEN_W'(1);
      run = b[7];
      for (int k = 0; k < 6; k++) begin
         run = run & b[6-k];
         if (run) begin
            n = n + SEEN_W'(1);
         end
      end
      return n;
   endfunction

   function automatic asm_type add_byte(input asm_type st, input logic [BYTE_W-1:0] b);
      asm_type r;
      r = st;
      if (st.expected == '0) begin
         r.expected  = lead_length(b);
         r.asm_bytes = {{(ASM_W-BYTE_W){1'b0}}, b};
         r.seen      = SEEN_W'(1);
      end else begin
         for (int k = 0; k < LANES; k++) begin
            if (st.seen == SEEN_W'(k)) begin
               r.asm_bytes[k*BYTE_W +: BYTE_W] = b;
            end
         end
         r.seen = st.seen + SEEN_W'(1);
      end
      return r;
   endfunction

endpackage

// ===== design/ued_ram.sv =====
// generic single write port ram with registered read
module ued_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== design/ued_ctrl.sv =====
// controller state machine sequencing transactions, row sweeps and results
module ued_ctrl
   import ued_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pend_in = status.emit;
               if (status.start_sweep) begin
                  state_in = S_SWEEP;
               end else if (status.emit) begin
                  state_in = S_RESULT;
               end
            end
         end
         S_SWEEP: begin
            if (status.sweep_done) begin
               state_in = pend_ff ? S_RESULT : S_IDLE;
            end
         end
         S_RESULT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == S_IDLE);
      rsp_valid  = (state_ff == S_RESULT);
      cmd.accept = req_valid && (state_ff == S_IDLE);
      cmd.step   = (state_ff == S_SWEEP);
   end

endmodule

// ===== design/ued_dp.sv =====
// datapath: character assembly, query store and distance row update
module ued_dp
   import ued_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic              req_mode,
   input  logic [BYTE_W-1:0] req_byte_value,
   input  logic              req_last,
   output status_type        status,
   output logic [DIST_W-1:0] rsp_distance,
   output logic              rsp_overflow
);

   localparam int DW  = $clog2(MAX_CHARS + 1);
   localparam int QAW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
   localparam logic [DW-1:0] MAX_V = DW'(MAX_CHARS);

   asm_type            asm_ff, asm_in;
   logic [DW-1:0]      qc_ff, qc_in;
   logic [DW-1:0]      cnt_ff, cnt_in;
   logic               ovf_ff, ovf_in;
   logic               covf_ff, covf_in;
   logic               busy_ff, busy_in;
   logic               qdone_ff, qdone_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic [DW-1:0]      idx_ff, idx_in;
   logic [DW-1:0]      diag_ff, diag_in;
   logic [DW-1:0]      left_ff, left_in;
   logic [DW-1:0]      last_ff, last_in;
   logic               first_ff, first_in;
   logic               byp_ff, byp_in;
   logic [CODE_W-1:0]  byp_data_ff;

   asm_type            st;
   logic [CODE_W-1:0]  cur_code;
   logic               q_we;
   logic [QAW-1:0]     q_waddr;
   logic [CODE_W-1:0]  q_wdata;
   logic [CODE_W-1:0]  q_rdata;
   logic [CODE_W-1:0]  q_cell;
   logic               d_we;
   logic [DW-1:0]      d_rdata;
   logic [DW-1:0]      rd_idx;
   logic [DW-1:0]      rd_qidx;
   logic [DW-1:0]      old_v;
   logic [DW-1:0]      min_v;
   logic [DW-1:0]      best;
   logic [DW-1:0]      dist_v;
   logic [DW+DIST_W-1:0] dist_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         asm_ff   <= '0;
         qc_ff    <= '0;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         covf_ff  <= 1'b0;
         busy_ff  <= 1'b0;
         qdone_ff <= 1'b1;
         first_ff <= 1'b1;
         byp_ff   <= 1'b0;
      end else begin
         asm_ff   <= asm_in;
         qc_ff    <= qc_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         covf_ff  <= covf_in;
         busy_ff  <= busy_in;
         qdone_ff <= qdone_in;
         first_ff <= first_in;
         byp_ff   <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      idx_ff      <= idx_in;
      diag_ff     <= diag_in;
      left_ff     <= left_in;
      last_ff     <= last_in;
      byp_data_ff <= q_wdata;
   end

   // query entry written in the same cycle as it is read
   assign byp_in = q_we && (q_waddr == rd_qidx[QAW-1:0]);
   assign q_cell = byp_ff ? byp_data_ff : q_rdata;

   // one row cell per sweep step
   always_comb begin
      old_v = first_ff ? idx_ff : d_rdata;
      min_v = left_ff;
      if (old_v < min_v) begin
         min_v = old_v;
      end
      if (diag_ff < min_v) begin
         min_v = diag_ff;
      end
      best = (q_cell == code_ff) ? diag_ff : (min_v + DW'(1));
   end

   always_comb begin
      st          = asm_ff;
      qc_in       = qc_ff;
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      covf_in     = covf_ff;
      busy_in     = busy_ff;
      qdone_in    = qdone_ff;
      first_in    = first_ff;
      code_in     = code_ff;
      idx_in      = idx_ff;
      diag_in     = diag_ff;
      left_in     = left_ff;
      last_in     = last_ff;
      q_we        = 1'b0;
      q_waddr     = qc_ff[QAW-1:0];
      q_wdata     = '0;
      cur_code    = '0;
      d_we        = 1'b0;
      status.start_sweep = 1'b0;
      status.emit        = 1'b0;
      status.sweep_done  = (idx_ff == qc_ff);

      if (cmd.accept) begin
         if (!req_mode) begin
            if (qdone_ff) begin
               busy_in  = 1'b0;
               st       = '0;
               qc_in    = '0;
               ovf_in   = 1'b0;
               qdone_in = 1'b0;
            end
            st = add_byte(st, req_byte_value);
            if (st.seen >= st.expected || req_last) begin
               q_wdata = {st.seen, st.asm_bytes};
               q_waddr = qc_in[QAW-1:0];
               if (qc_in < MAX_V) begin
                  q_we  = 1'b1;
                  qc_in = qc_in + DW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               st = '0;
            end
            if (req_last) begin
               qdone_in = 1'b1;
            end
         end else begin
            if (!qdone_ff) begin
               if (st.seen != '0) begin
                  q_wdata = {st.seen, st.asm_bytes};
                  if (qc_in < MAX_V) begin
                     q_we  = 1'b1;
                     qc_in = qc_in + DW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               st       = '0;
               qdone_in = 1'b1;
            end
            if (!busy_ff) begin
               cnt_in   = '0;
               covf_in  = 1'b0;
               busy_in  = 1'b1;
            end
            st = add_byte(st, req_byte_value);
            if (st.seen >= st.expected || req_last) begin
               cur_code = {st.seen, st.asm_bytes};
               st       = '0;
               if (cnt_in >= MAX_V) begin
                  covf_in = 1'b1;
               end else begin
                  diag_in  = cnt_in;
                  first_in = (cnt_in == '0);
                  cnt_in   = cnt_in + DW'(1);
                  left_in  = cnt_in;
                  code_in  = cur_code;
                  idx_in   = DW'(1);
                  status.start_sweep = (qc_in != '0);
               end
            end
            if (req_last) begin
               busy_in     = 1'b0;
               status.emit = 1'b1;
            end
         end
      end

      if (cmd.step) begin
         d_we    = 1'b1;
         left_in = best;
         diag_in = old_v;
         idx_in  = idx_ff + DW'(1);
         if (idx_ff == qc_ff) begin
            last_in = best;
         end
      end

      asm_in = st;
   end

   assign rd_idx  = cmd.accept ? DW'(1) : (idx_ff + DW'(1));
   assign rd_qidx = rd_idx - DW'(1);

   ued_ram #(
      .WIDTH(CODE_W),
      .DEPTH(MAX_CHARS)
   ) u_query_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (rd_qidx[QAW-1:0]),
      .rd_data (q_rdata)
   );

   ued_ram #(
      .WIDTH(DW),
      .DEPTH(MAX_CHARS + 1)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (idx_ff),
      .wr_data (best),
      .rd_addr (rd_idx),
      .rd_data (d_rdata)
   );

   assign dist_v       = (qc_ff == '0) ? cnt_ff : last_ff;
   assign dist_ext     = {{DIST_W{1'b0}}, dist_v};
   assign rsp_distance = dist_ext[DIST_W-1:0];
   assign rsp_overflow = ovf_ff | covf_ff;

endmodule

// ===== design/utf8_char_edit_distance_top.sv =====
// a byte that closes a candidate character starts a row sweep over the stored query
// characters, one cell per sweep step; no byte is taken during the sweep
// throughput: one transaction at a time, row update bounded by the shared cell unit
// the result is held until taken; no new byte is taken while a result waits
// reset: synchronous, empty query, no candidate in progress; no clearing pass
// top level of the character level edit distance block
module utf8_char_edit_distance_top
   import ued_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  logic [BYTE_W-1:0] req_byte_value,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DIST_W-1:0] rsp_distance,
   output logic              rsp_overflow
);

   cmd_type    cmd;
   status_type status;

   ued_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ued_dp #(
      .MAX_CHARS(MAX_CHARS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_mode       (req_mode),
      .req_byte_value (req_byte_value),
      .req_last       (req_last),
      .status         (status),
      .rsp_distance   (rsp_distance),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

// ===== tb/utf8_char_edit_distance_top_tb.sv =====
// testbench for the character level edit distance block with a scoreboard class
module utf8_char_edit_distance_top_tb;
   import ued_pkg::*;

   localparam int NCH = MAX_CHARS_DEF;

   class distance_board;
      logic [58:0] q_chars[NCH];
      int          q_count;
      int          row[NCH+1];
      int          c_count;
      logic [55:0] asm_bytes;
      int          b_exp;
      int          b_seen;
      bit          q_done;
      bit          q_ovf;
      bit          c_ovf;
      bit          c_busy;
      logic [DIST_W-1:0] exp_dist[$];
      bit                exp_ovf[$];
      int          errors;
      int          checked;

      function new();
         q_count = 0; c_count = 0; asm_bytes = '0; b_exp = 0; b_seen = 0;
         q_done = 1; q_ovf = 0; c_ovf = 0; c_busy = 0; errors = 0; checked = 0;
         for (int i = 0; i <= NCH; i++) row[i] = i;
         for (int i = 0; i < NCH; i++) q_chars[i] = '0;
      endfunction

      function int char_len(logic [7:0] b);
         int n;
         n = 1;
         if (!b[7]) return 1;
         for (int k = 0; k < 6; k++) begin
            if (b[6-k]) n++;
            else break;
         end
         return n;
      endfunction

      function logic [58:0] take_char();
         logic [58:0] code;
         code = {3'(b_seen), asm_bytes};
         asm_bytes = '0; b_exp = 0; b_seen = 0;
         return code;
      endfunction

      function void add_byte(logic [7:0] b);
         if (b_exp == 0) begin
            b_exp = char_len(b);
            asm_bytes = {48'd0, b};
            b_seen = 1;
         end else begin
            asm_bytes[8*(b_seen & 7) +: 8] = b;
            b_seen = (b_seen + 1) & 7;
         end
      endfunction

      function void query_commit();
         logic [58:0] code;
         code = take_char();
         if (q_count < NCH) q_chars[q_count++] = code;
         else q_ovf = 1;
      endfunction

      function void cand_commit();
         logic [58:0] code;
         int diag, old, best;
         code = take_char();
         if (c_count >= NCH) begin
            c_ovf = 1;
            return;
         end
         c_count++;
         diag = row[0];
         row[0] = c_count;
         for (int i = 1; i <= q_count; i++) begin
            old = row[i];
            if (q_chars[i-1] == code) best = diag;
            else begin
               best = row[i-1] + 1;
               if (old + 1 < best) best = old + 1;
               if (diag + 1 < best) best = diag + 1;
            end
            diag = old;
            row[i] = best;
         end
      endfunction

      function void note_input(bit mode, logic [7:0] b, bit last);
         if (!mode) begin
            if (q_done) begin
               c_busy = 0; asm_bytes = '0; b_exp = 0; b_seen = 0;
               q_count = 0; q_ovf = 0; q_done = 0;
            end
            add_byte(b);
            if (b_seen >= b_exp || last) query_commit();
            if (last) q_done = 1;
            return;
         end
         if (!q_done) begin
            if (b_seen != 0) query_commit();
            q_done = 1;
         end
         if (!c_busy) begin
            for (int i = 0; i <= NCH; i++) row[i] = i;
            c_count = 0; c_ovf = 0; c_busy = 1;
         end
         add_byte(b);
         if (b_seen >= b_exp || last) cand_commit();
         if (!last) return;
         c_busy = 0;
         exp_dist.push_back(DIST_W'(row[q_count]));
         exp_ovf.push_back(q_ovf | c_ovf);
      endfunction

      function void check_result(logic [DIST_W-1:0] d, logic o);
         if (exp_dist.size() == 0) begin
            report_error($sformatf("unexpected result distance %0d", d));
            return;
         end
         checked++;
         if (d !== exp_dist[0] || o !== exp_ovf[0])
            report_error($sformatf("distance %0d overflow %0b, expected %0d %0b",
                                   d, o, exp_dist[0], exp_ovf[0]));
         void'(exp_dist.pop_front());
         void'(exp_ovf.pop_front());
      endfunction

      function void report_error(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic              req_mode = 0;
   logic [BYTE_W-1:0] req_byte_value = '0;
   logic              req_last = 0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [DIST_W-1:0] rsp_distance;
   logic              rsp_overflow;

   distance_board board = new();
   int  burst_left = 0;
   bit  hold_off = 0;
   int  sent = 0;
   bit  stim_done = 0;

   utf8_char_edit_distance_top uut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // send one byte, with bursts and gaps in front
   task automatic send_byte(bit mode, logic [7:0] b, bit last);
      while (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(1, 40);
         else begin
            req_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
      req_valid <= 1;
      req_mode <= mode;
      req_byte_value <= b;
      req_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_input(mode, b, last);
      sent++;
      burst_left--;
   endtask

   function automatic logic [7:0] rand_lead();
      case ($urandom_range(0, 5))
         0: return 8'($urandom_range(0, 127));
         1: return 8'hC0 | 8'($urandom_range(0, 31));
         2: return 8'hE0 | 8'($urandom_range(0, 15));
         3: return 8'hF0 | 8'($urandom_range(0, 7));
         4: return 8'($urandom_range(0, 255));
         default: return 8'h61 + 8'($urandom_range(0, 2));
      endcase
   endfunction

   // random string, mostly well-formed, biased to a small alphabet so matches are frequent
   task automatic send_string(bit mode, int nchars);
      logic [7:0] lead;
      int len;
      for (int c = 0; c < nchars; c++) begin
         lead = rand_lead();
         len = board.char_len(lead);
         send_byte(mode, lead, (c == nchars - 1) && len == 1);
         for (int k = 1; k < len; k++)
            send_byte(mode, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                      : 8'h80 | 8'($urandom_range(0, 1)), (c == nchars - 1) && k == len - 1);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_distance, rsp_overflow);
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (hold_off) rsp_ready <= 0;
      else rsp_ready <= (($urandom_range(0, 7) != 0) || (sent % 200 < 60));
   end

   initial begin
      wait (sent > 300);
      @(posedge clock);
      hold_off <= 1;
      repeat (300) @(posedge clock);
      hold_off <= 0;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // empty query, single characters, full lead bytes, cut-short characters
      send_byte(1, 8'h00, 1);
      send_byte(0, 8'h61, 0);
      send_byte(0, 8'hFF, 0);
      send_byte(0, 8'h80, 1);
      send_byte(1, 8'h61, 0);
      send_byte(1, 8'hFF, 0);
      send_byte(1, 8'h80, 1);
      send_byte(1, 8'hFE, 0);
      send_byte(1, 8'h7F, 1);
      // interrupted query, then abandoned candidate
      send_byte(0, 8'hC3, 0);
      send_byte(1, 8'hC3, 0);
      send_byte(0, 8'h62, 1);
      send_byte(1, 8'h62, 1);
      // overflow on query and candidate
      send_string(0, 70);
      send_string(1, 66);
      send_string(0, 64);
      send_string(1, 64);
      send_string(1, 2);
      while (sent < 950) begin
         case ($urandom_range(0, 9))
            0: send_byte($urandom_range(0, 1), 8'($urandom_range(0, 255)),
                         $urandom_range(0, 1));
            1, 2: send_string(0, $urandom_range(0, 3) == 0 ? $urandom_range(60, 68)
                              : $urandom_range(1, 8));
            default: send_string(1, $urandom_range(0, 15) == 0 ? $urandom_range(60, 68)
                                 : $urandom_range(1, 8));
         endcase
      end
      req_valid <= 0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (board.exp_dist.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("sent %0d bytes, checked %0d distances", sent, board.checked);
      $display("strings covered well-formed and broken UTF-8, overflow and stalls");
      if (board.errors == 0 && board.exp_dist.size() == 0)
         $display("utf8_char_edit_distance_top_tb: PASS");
      else
         $display("utf8_char_edit_distance_top_tb: FAIL");
      $finish;
   end

   initial begin
      #20000000;
      $display("utf8_char_edit_distance_top_tb: FAIL");
      $finish;
   end
endmodule
